// File: rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg : shared constants for the nearest template classifier
// Sizes, command codes, sequencer states and register map.
// ----------------------------------------------------------------------------
package ntc_pkg;

   localparam int NUM_CLASSES = 8;
   localparam int FEATURE_LEN = 256;
   localparam int STORE_DEPTH = NUM_CLASSES * FEATURE_LEN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CLS_W       = $clog2(NUM_CLASSES);

   localparam int DIST_W = 48;
   localparam int VAL_W  = 16;
   localparam int DIFF_W = VAL_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int SQ_W   = 2 * VAL_W;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Item commands
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_FEATURE = 1'b1;

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // Register map
   localparam int                CSR_ADDR_W         = 4;
   localparam int                CSR_DATA_W         = 64;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD_ADDR = 4'h0;

endpackage

// File: rtl/nearest_template_classifier.sv
// ----------------------------------------------------------------------------
// nearest_template_classifier : squared-distance nearest template search
// Template store, shared subtract-square-accumulate unit and class scan.
// ----------------------------------------------------------------------------
// Usage
//   req_* channel: a load item (command 0) writes one template element of one
//   class into the template store in the transfer cycle. A feature item
//   (command 1) starts a sweep over all classes: one class a cycle goes
//   through a single shared unit that reads the template, squares the
//   difference and adds it to that class's saturating 48-bit accumulator.
//   A load leaves req_ready high; a feature item holds req_ready low while
//   the sequencer issues one class per cycle (state RUN) through the
//   three-stage read / square / accumulate unit and then drains it (DRAIN).
//   On a last element the same pass scans the new distances in class order,
//   keeps the smallest one strictly below match_threshold (the lower class
//   on ties) and clears the accumulators; state DONE then loads the output
//   register, so rsp_valid rises and req_ready returns with it.
//   The result sits in an output register, so new items are taken while it
//   waits; if the receiver still stalls when the next result is ready, the
//   sequencer holds until rsp_ready frees the register.
//   Reset clears the accumulators, sets the threshold to all ones and
//   leaves the template store unwritten; there is no clearing pass.
//   Configuration: match_threshold at byte address 0 (64-bit data port).
// ----------------------------------------------------------------------------
module nearest_template_classifier
   import ntc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [2:0]            req_class_index,
   input  logic [7:0]            req_element_index,
   input  logic signed [15:0]    req_element_value,
   input  logic                  req_last_element,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_matched,
   output logic [2:0]            rsp_class_found,
   output logic [47:0]           rsp_best_distance,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [DIST_W-1:0] threshold_ff;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready & (paddr == CSR_THRESHOLD_ADDR);
   assign prdata = (paddr == CSR_THRESHOLD_ADDR) ? CSR_DATA_W'(threshold_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= DIST_MAX;
      end else if (csr_wr) begin
         threshold_ff <= pwdata[DIST_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Sequencer and item registers
   // ------------------------------------------------------------------
   logic [1:0]        state_ff, state_in;
   logic [CLS_W-1:0]  issue_cnt_ff, issue_cnt_in;
   logic              item_last_ff;
   logic              elem_ok_ff;
   logic [7:0]        elem_ff;
   logic [VAL_W-1:0]  val_ff;

   logic              req_xfer;
   logic              load_xfer;
   logic              feat_xfer;
   logic              load_ok;
   logic              req_elem_ok;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_xfer    = req_valid & req_ready;
   assign load_xfer   = req_xfer & (req_command == CMD_LOAD);
   assign feat_xfer   = req_xfer & (req_command == CMD_FEATURE);
   assign req_elem_ok = 32'(req_element_index) < FEATURE_LEN;
   assign load_ok     = (32'(req_class_index) < NUM_CLASSES) & req_elem_ok;

   // pipeline of the shared unit: read -> square -> accumulate -> compare
   logic              v1_ff, v2_ff, v3_ff;
   logic [CLS_W-1:0]  c1_ff, c2_ff, c3_ff;
   logic              pipe_busy;

   assign pipe_busy = v1_ff | v2_ff | v3_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_matched_ff;
   logic [2:0]        rsp_class_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_load;

   // running best
   logic              hit_ff;
   logic [CLS_W-1:0]  found_ff;
   logic [DIST_W-1:0] best_ff;

   always_comb begin
      state_in     = state_ff;
      issue_cnt_in = issue_cnt_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (feat_xfer) begin
               state_in     = ST_RUN;
               issue_cnt_in = '0;
            end
         end
         ST_RUN: begin
            // issue one class a cycle
            if (issue_cnt_ff == CLS_W'(NUM_CLASSES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = item_last_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         item_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (feat_xfer) begin
            item_last_ff <= req_last_element;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (feat_xfer) begin
         elem_ff    <= req_element_index;
         val_ff     <= req_element_value;
         elem_ok_ff <= req_elem_ok;
      end
      if (rsp_load) begin
         rsp_matched_ff <= hit_ff;
         rsp_class_ff   <= hit_ff ? 3'(found_ff) : 3'd0;
         rsp_dist_ff    <= best_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_class_found   = rsp_class_ff;
   assign rsp_best_distance = rsp_dist_ff;

   // ------------------------------------------------------------------
   // Template store: write on load transfers, registered read
   // ------------------------------------------------------------------
   logic [VAL_W-1:0]  tmpl_mem [STORE_DEPTH];
   logic [VAL_W-1:0]  mem_rd_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   assign wr_addr = ADDR_W'(32'(req_class_index) * FEATURE_LEN + 32'(req_element_index));
   assign rd_addr = ADDR_W'(32'(issue_cnt_ff) * FEATURE_LEN + 32'(elem_ff));

   always_ff @(posedge clock) begin
      if (load_xfer && load_ok) begin
         tmpl_mem[wr_addr] <= req_element_value;
      end
      mem_rd_ff <= tmpl_mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // Shared subtract-square-accumulate unit
   // ------------------------------------------------------------------
   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [DIST_W:0]          sum;
   logic [DIST_W-1:0]        sum_sat;
   logic [DIST_W-1:0]        sum_ff;
   logic [DIST_W-1:0]        acc_ff [NUM_CLASSES];

   assign diff  = {val_ff[VAL_W-1], val_ff} - {mem_rd_ff[VAL_W-1], mem_rd_ff};
   assign prod  = diff * diff;
   // drop elements beyond the vector length
   assign sq_in = elem_ok_ff ? prod[SQ_W-1:0] : '0;

   assign sum     = {1'b0, acc_ff[c2_ff]} + (DIST_W + 1)'(sq_ff);
   assign sum_sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == ST_RUN);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff  <= issue_cnt_ff;
      c2_ff  <= c1_ff;
      c3_ff  <= c2_ff;
      sq_ff  <= sq_in;
      sum_ff <= sum_sat;
   end

   // accumulators: clear on the last element of a vector
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (v2_ff) begin
         acc_ff[c2_ff] <= item_last_ff ? '0 : sum_sat;
      end
   end

   // class scan in index order: strict compare keeps the lower index on ties
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (feat_xfer) begin
         hit_ff <= 1'b0;
      end else if (v3_ff && item_last_ff && (sum_ff < best_ff)) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (feat_xfer) begin
         best_ff  <= threshold_ff;
         found_ff <= '0;
      end else if (v3_ff && item_last_ff && (sum_ff < best_ff)) begin
         best_ff  <= sum_ff;
         found_ff <= c3_ff;
      end
   end

endmodule

// File: rtl/ntc_checker.sv
// ----------------------------------------------------------------------------
// ntc_checker : port-level checks for the nearest template classifier
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module ntc_checker
   import ntc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_matched,
   input logic [2:0]  rsp_class_found,
   input logic        pready
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // no match reports class zero
   a_nomatch_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_class_found == 3'd0)
      else $error("class reported without a match");

   // leave reset idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // a feature transfer starts a multi-cycle sweep
   a_feature_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_FEATURE |=> !req_ready)
      else $error("input taken during a class sweep");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind nearest_template_classifier ntc_checker u_ntc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_command     (req_command),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_matched     (rsp_matched),
   .rsp_class_found (rsp_class_found),
   .pready          (pready)
);
